FILE: sv/cor_pkg.sv
// Shared constants, codes and types for the circle octant rasterizer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cor_pkg;

    localparam int COORD_W  = 16;
    localparam int RADIUS_W = COORD_W - 1;
    localparam int OUT_W    = COORD_W + 1;
    localparam int SQ_W     = 32;
    localparam int PROD_W   = 2 * RADIUS_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int PHASES = 8;
    localparam int PH_W   = $clog2(PHASES);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(PHASES - 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               fill;
        logic               done;
    } job_t;

endpackage

FILE: sv/cor_front.sv
// Front end: accepts items, runs one midpoint iteration per step item and
// queues the iteration values for the back end. Depends on cor_pkg.
`timescale 1ns / 1ps

module cor_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic signed [cor_pkg::COORD_W-1:0] center_x,
    input  logic signed [cor_pkg::COORD_W-1:0] center_y,
    input  logic [cor_pkg::RADIUS_W-1:0]      radius,
    input  logic                              fill,
    output logic                              q_push,
    output cor_pkg::job_t                     q_data,
    input  logic                              q_full
);

    logic [cor_pkg::COORD_W-1:0] cx_reg, cx_next;
    logic [cor_pkg::COORD_W-1:0] cy_reg, cy_next;
    logic                        fill_reg, fill_next;
    logic [cor_pkg::COORD_W-1:0] x_reg, x_next;
    logic [cor_pkg::COORD_W-1:0] y_reg, y_next;
    logic [cor_pkg::SQ_W-1:0]    sq_reg, sq_next;
    logic [cor_pkg::SQ_W-1:0]    trig_reg, trig_next;
    logic                        active_reg, active_next;

    logic                        in_fire;
    logic                        dec;
    logic [cor_pkg::COORD_W-1:0] x_step;
    logic [cor_pkg::COORD_W-1:0] y_step;
    logic                        step_done;
    logic [cor_pkg::PROD_W-1:0]  r_prod;
    logic [cor_pkg::SQ_W-1:0]    r_sq;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    assign dec       = $signed(sq_reg) <= $signed(trig_reg);
    assign x_step    = dec ? x_reg - cor_pkg::COORD_W'(1) : x_reg;
    assign y_step    = y_reg + cor_pkg::COORD_W'(1);
    assign step_done = !(x_step > y_step);
    assign r_prod    = cor_pkg::PROD_W'(radius) * cor_pkg::PROD_W'(radius);
    assign r_sq      = cor_pkg::SQ_W'(r_prod);

    assign q_push = in_fire && (opcode == cor_pkg::OP_STEP) && active_reg
                    && (x_reg > y_reg);

    always_comb
    begin
        q_data.cx   = cx_reg;
        q_data.cy   = cy_reg;
        q_data.x    = x_step;
        q_data.y    = y_reg;
        q_data.fill = fill_reg;
        q_data.done = step_done;
    end

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        fill_next   = fill_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        sq_next     = sq_reg;
        trig_next   = trig_reg;
        active_next = active_reg;
        if (in_fire && (opcode == cor_pkg::OP_START))
        begin
            cx_next     = center_x;
            cy_next     = center_y;
            fill_next   = fill;
            x_next      = cor_pkg::COORD_W'(radius);
            y_next      = '0;
            sq_next     = r_sq;
            trig_next   = r_sq - (cor_pkg::SQ_W'(radius) << 1) - cor_pkg::SQ_W'(1);
            active_next = (radius != '0);
        end
        else if (q_push)
        begin
            x_next      = x_step;
            y_next      = y_step;
            sq_next     = sq_reg - ((cor_pkg::SQ_W'(y_reg) << 1) + cor_pkg::SQ_W'(1));
            trig_next   = dec ? trig_reg - ((cor_pkg::SQ_W'(x_step) << 1)
                                            - cor_pkg::SQ_W'(1))
                              : trig_reg;
            active_next = !step_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            fill_reg   <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            sq_reg     <= '0;
            trig_reg   <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            fill_reg   <= fill_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            sq_reg     <= sq_next;
            trig_reg   <= trig_next;
            active_reg <= active_next;
        end
    end

    // A circle in progress always has its running x above its running y.
    a_active_order: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (x_reg > y_reg))
        else $error("active circle with x not above y");

endmodule

FILE: sv/cor_fifo.sv
// Short job queue between the front and back ends of the rasterizer.
// Depends on cor_pkg for the job type and the depth.
`timescale 1ns / 1ps

module cor_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cor_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output cor_pkg::job_t dout,
    output logic          empty
);

    cor_pkg::job_t               mem_reg [cor_pkg::Q_DEPTH];
    logic [cor_pkg::Q_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cor_pkg::Q_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cor_pkg::Q_CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == cor_pkg::Q_CW'(cor_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == cor_pkg::Q_AW'(cor_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + cor_pkg::Q_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cor_pkg::Q_AW'(cor_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + cor_pkg::Q_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + cor_pkg::Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - cor_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue underflow");

endmodule

FILE: sv/cor_back.sv
// Back end: takes one job from the queue and emits its eight mirrored
// points or spans through a registered output. Depends on cor_pkg.
`timescale 1ns / 1ps

module cor_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    output logic                              q_pop,
    input  cor_pkg::job_t                     q_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cor_pkg::OUT_W-1:0]  span_x_low,
    output logic signed [cor_pkg::OUT_W-1:0]  span_x_high,
    output logic signed [cor_pkg::OUT_W-1:0]  span_y,
    output logic                              last,
    output logic                              done_res
);

    cor_pkg::job_t            job_reg, job_next;
    logic                     job_valid_reg, job_valid_next;
    logic [cor_pkg::PH_W-1:0] ph_reg, ph_next;

    logic                     out_valid_reg, out_valid_next;
    logic [cor_pkg::OUT_W-1:0] lo_reg, lo_next;
    logic [cor_pkg::OUT_W-1:0] hi_reg, hi_next;
    logic [cor_pkg::OUT_W-1:0] y_reg, y_next;
    logic                     last_reg, last_next;
    logic                     done_reg, done_next;

    logic                     load_out;
    logic                     fin;
    logic [cor_pkg::COORD_W-1:0] a_val;
    logic [cor_pkg::COORD_W-1:0] b_val;
    logic [cor_pkg::OUT_W-1:0] cx_e;
    logic [cor_pkg::OUT_W-1:0] cy_e;
    logic [cor_pkg::OUT_W-1:0] a_e;
    logic [cor_pkg::OUT_W-1:0] b_e;
    logic [cor_pkg::OUT_W-1:0] xt;
    logic [cor_pkg::OUT_W-1:0] yt;

    assign load_out = job_valid_reg && (!out_valid_reg || out_ready);
    assign fin      = load_out && (ph_reg == cor_pkg::PH_LAST);
    assign q_pop    = !q_empty && (!job_valid_reg || fin);

    // Phase bit 2 swaps the roles of x and y, bit 0 picks the right side
    // and bit 1 picks the lower half.
    assign a_val = ph_reg[2] ? job_reg.y : job_reg.x;
    assign b_val = ph_reg[2] ? job_reg.x : job_reg.y;
    assign cx_e  = {job_reg.cx[cor_pkg::COORD_W-1], job_reg.cx};
    assign cy_e  = {job_reg.cy[cor_pkg::COORD_W-1], job_reg.cy};
    assign a_e   = {1'b0, a_val};
    assign b_e   = {1'b0, b_val};
    assign xt    = ph_reg[0] ? cx_e + a_e : cx_e - a_e;
    assign yt    = ph_reg[1] ? cy_e - b_e : cy_e + b_e;

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        ph_next        = ph_reg;
        out_valid_next = out_valid_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        y_next         = y_reg;
        last_next      = last_reg;
        done_next      = done_reg;

        if (load_out)
        begin
            out_valid_next = 1'b1;
            lo_next        = (ph_reg[0] && job_reg.fill) ? cx_e : xt;
            hi_next        = (!ph_reg[0] && job_reg.fill) ? cx_e : xt;
            y_next         = yt;
            last_next      = (ph_reg == cor_pkg::PH_LAST);
            done_next      = job_reg.done;
            ph_next        = ph_reg + cor_pkg::PH_W'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            job_next       = q_data;
            job_valid_next = 1'b1;
            ph_next        = '0;
        end
        else if (fin)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        y_reg   <= y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            ph_reg        <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            done_reg      <= done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign span_x_low  = lo_reg;
    assign span_x_high = hi_reg;
    assign span_y      = y_reg;
    assign last        = last_reg;
    assign done_res    = done_reg;

    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid_reg |-> (ph_reg == '0))
        else $error("phase counter running without a job");

    a_last_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> (out_valid_reg && last_reg))
        else $error("final phase did not mark last");

    a_pop_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && job_valid_reg) |-> (ph_reg == cor_pkg::PH_LAST))
        else $error("job replaced before all eight results");

endmodule

FILE: sv/circle_octant_rasterizer.sv
// Circle octant rasterizer: the top level joining front end, job queue and
// back end. Depends on cor_pkg, cor_front, cor_fifo and cor_back.
// A start item (opcode 0) loads a circle and yields no result; a step item
// (opcode 1) runs one midpoint iteration and yields eight results, one per
// cycle while out_ready is high, the eighth flagged by last, all flagged by
// done_res when the circle ends there. A step with no circle in progress
// yields nothing. Every item is accepted while the two-entry job queue has
// room, so the front end runs up to two steps ahead; the single result port
// in the back end sets the sustained rate at one step per eight results.
`timescale 1ns / 1ps

module circle_octant_rasterizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic signed [cor_pkg::COORD_W-1:0] center_x,
    input  logic signed [cor_pkg::COORD_W-1:0] center_y,
    input  logic [cor_pkg::RADIUS_W-1:0]      radius,
    input  logic                              fill,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cor_pkg::OUT_W-1:0]  span_x_low,
    output logic signed [cor_pkg::OUT_W-1:0]  span_x_high,
    output logic signed [cor_pkg::OUT_W-1:0]  span_y,
    output logic                              last,
    output logic                              done_res
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    cor_pkg::job_t q_in;
    cor_pkg::job_t q_out;

    cor_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .fill     (fill),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    cor_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    cor_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_data      (q_out),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .span_x_low  (span_x_low),
        .span_x_high (span_x_high),
        .span_y      (span_y),
        .last        (last),
        .done_res    (done_res)
    );

endmodule
